>>> sv/fp32a_pkg.sv
// Package for the single-precision adder: field widths, constants, class codes.
// No dependencies.
`default_nettype none
package fp32a_pkg;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CLASS_W = 2;
	localparam int unsigned MAG_W = 28;
	localparam logic [7:0] EXP_MAX = 8'd255;
	localparam logic [31:0] CANON_NAN = 32'h7FFF_FFFF;
	localparam logic [1:0] CLS_NORMAL = 2'd0;
	localparam logic [1:0] CLS_SUBNORM = 2'd1;
	localparam logic [1:0] CLS_INF = 2'd2;
	localparam logic [1:0] CLS_NAN = 2'd3;

	typedef struct packed {
		logic [31:0] bits;
		logic [1:0] cls;
	} fp32a_res_t;
endpackage
`default_nettype wire

>>> sv/fp32a_core.sv
// Combinational add datapath: unpack, align, add, normalize, round, pack.
// Depends on fp32a_pkg.
`default_nettype none
module fp32a_core (
	input wire logic [31:0] a,
	input wire logic [31:0] b,
	output fp32a_pkg::fp32a_res_t res
);
	import fp32a_pkg::*;

	logic sa, sb, nan_a, nan_b, inf_a, inf_b;
	logic [7:0] ea, eb, eae, ebe;
	logic [22:0] fa, fb;
	logic [26:0] ma0, mb0, ma, mb, big, lit, lit_sh;
	logic [8:0] e0, e1;
	logic [7:0] d;
	logic [27:0] mag;
	logic sign;
	logic [4:0] lz;
	logic [26:0] nm;
	logic [24:0] m;
	logic [2:0] grs;
	logic [26:0] lost;
	logic swap;

	always_comb begin
		sa = a[31]; sb = b[31];
		ea = a[30:23]; eb = b[30:23];
		fa = a[22:0]; fb = b[22:0];
		nan_a = (ea == EXP_MAX) && (fa != 23'd0);
		nan_b = (eb == EXP_MAX) && (fb != 23'd0);
		inf_a = (ea == EXP_MAX) && (fa == 23'd0);
		inf_b = (eb == EXP_MAX) && (fb == 23'd0);
		ma0 = {(ea != 8'd0), fa, 3'b000};
		mb0 = {(eb != 8'd0), fb, 3'b000};
		eae = (ea == 8'd0) ? 8'd1 : ea;
		ebe = (eb == 8'd0) ? 8'd1 : eb;
		swap = ebe > eae;
		big = swap ? mb0 : ma0;
		lit = swap ? ma0 : mb0;
		d = swap ? (ebe - eae) : (eae - ebe);
		e0 = {1'b0, swap ? ebe : eae};
		// sticky right shift of the smaller operand
		lost = lit & ~(27'h7FF_FFFF << d[4:0]);
		if (d >= 8'd27) begin
			lit_sh = {26'd0, (lit != 27'd0)};
		end else begin
			lit_sh = (lit >> d[4:0]) | {26'd0, (lost != 27'd0)};
		end
		ma = swap ? lit_sh : big;
		mb = swap ? big : lit_sh;
		if (sa == sb) begin
			mag = {1'b0, ma} + {1'b0, mb}; sign = sa;
		end else if (ma >= mb) begin
			mag = {1'b0, ma - mb}; sign = sa;
		end else begin
			mag = {1'b0, mb - ma}; sign = sb;
		end
		// leading zero count within the 27-bit window
		lz = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (mag[i]) lz = 5'(26 - i);
		end
		e1 = e0;
		if (mag[27]) begin
			nm = mag[27:1] | {26'd0, mag[0]};
			e1 = e0 + 9'd1;
		end else if (e0 - 9'd1 < {4'd0, lz}) begin
			nm = mag[26:0] << (e0 - 9'd1);
			e1 = 9'd1;
		end else begin
			nm = mag[26:0] << lz;
			e1 = e0 - {4'd0, lz};
		end
		grs = nm[2:0];
		m = {1'b0, nm[26:3]};
		if (grs > 3'd4 || (grs == 3'd4 && m[0])) m = m + 25'd1;
		if (m[24]) begin
			m = m >> 1; e1 = e1 + 9'd1;
		end

		if (nan_a || nan_b || (inf_a && inf_b && sa != sb)) begin
			res = '{bits: CANON_NAN, cls: CLS_NAN};
		end else if (inf_a) begin
			res = '{bits: a, cls: CLS_INF};
		end else if (inf_b) begin
			res = '{bits: b, cls: CLS_INF};
		end else if (mag == 28'd0) begin
			res = '{bits: {(sa & sb), 31'd0}, cls: CLS_NORMAL};
		end else if (e1 >= {1'b0, EXP_MAX}) begin
			res = '{bits: {sign, EXP_MAX, 23'd0}, cls: CLS_INF};
		end else if (!m[23]) begin
			res = '{bits: {sign, 8'd0, m[22:0]}, cls: CLS_SUBNORM};
		end else begin
			res = '{bits: {sign, e1[7:0], m[22:0]}, cls: CLS_NORMAL};
		end
	end
endmodule
`default_nettype wire

>>> sv/fp32_adder.sv
// Top level of the single-precision adder: input register, datapath, output register.
// Depends on fp32a_pkg and fp32a_core.
//
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | operand_a, operand_b
//  out     | out_valid / out_ready  | sum_bits, result_class
//
// One addition per cycle unless stalled; operands are registered, then the result.
// The datapath is one combinational pass between the operand and result registers.
// A stalled output holds the result register and backs up into the operand register.
// Reset clears both valid flags.
`default_nettype none
module fp32_adder (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [31:0] operand_a,
	input wire logic [31:0] operand_b,
	output logic out_valid,
	input wire logic out_ready,
	output logic [31:0] sum_bits,
	output logic [1:0] result_class
);
	import fp32a_pkg::*;

	logic v_s1;
	logic [31:0] a_s1, b_s1;
	fp32a_res_t res_c, res_s2;
	logic adv_s2;

	assign adv_s2 = !out_valid || out_ready;
	assign in_ready = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv_s2) out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			a_s1 <= operand_a;
			b_s1 <= operand_b;
		end
		if (adv_s2 && v_s1) res_s2 <= res_c;
	end

	fp32a_core u_core (.a(a_s1), .b(b_s1), .res(res_c));

	assign sum_bits = res_s2.bits;
	assign result_class = res_s2.cls;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sum_bits))
		else $error("result dropped under stall");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_class == CLS_NAN |-> sum_bits == CANON_NAN)
		else $error("nan not canonical");
	a_inf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_class == CLS_INF |-> sum_bits[30:0] == {EXP_MAX, 23'd0})
		else $error("bad infinity");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_s2 |=> out_valid)
		else $error("stage one result lost");
`endif
endmodule
`default_nettype wire
